/* design/wsce_pkg.sv */
// Shared constants and types for the window slew and clamp engine.
package wsce_pkg;

    // Default sizing of the window table and coordinate storage
    localparam int WINDOWS_DEF    = 8;
    localparam int COORD_BITS_DEF = 12;

    // Fixed field widths on the stream and config ports
    localparam int FIELD_W    = 12;
    localparam int WIN_W      = 3;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Input tdata layout, lowest bit first
    localparam int IN_WIN_LSB   = 0;
    localparam int IN_X_LSB     = 3;
    localparam int IN_Y_LSB     = 15;
    localparam int IN_W_LSB     = 27;
    localparam int IN_H_LSB     = 39;
    localparam int IN_BOUND_BIT = 51;
    localparam int S_TDATA_W    = 56;

    // Output tdata layout, lowest bit first
    localparam int OUT_WIN_LSB   = 0;
    localparam int OUT_X_LSB     = 3;
    localparam int OUT_Y_LSB     = 15;
    localparam int OUT_W_LSB     = 27;
    localparam int OUT_H_LSB     = 39;
    localparam int OUT_MOVED_BIT = 51;
    localparam int OUT_DEGEN_BIT = 52;
    localparam int M_TDATA_W     = 56;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HIDE = 2'd2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_STEP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH       = 2'd3;

    // Config reset values
    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic [CFG_DATA_W-1:0] MOVE_STEP_RST    = 12'd20;
    localparam logic                  SMOOTH_RST       = 1'b1;

    // Field slots of one window table row
    localparam int ROW_FIELDS = 8;
    localparam int F_NX = 0;
    localparam int F_NY = 1;
    localparam int F_NW = 2;
    localparam int F_NH = 3;
    localparam int F_GX = 4;
    localparam int F_GY = 5;
    localparam int F_GW = 6;
    localparam int F_GH = 7;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* design/wsce_div.sv */
// Restoring divider, one quotient bit per cycle, quotient known to fit W bits.
module wsce_div #(
    parameter int W = wsce_pkg::COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [2*W-1:0]        num,
    input  logic [W-1:0]          den,
    output wsce_pkg::div_stat_t   stat,
    output logic [W-1:0]          quot
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     q_reg;
    logic [W-1:0]     den_reg;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    // Shift next dividend bit into the partial remainder
    assign trial = {rem_reg, q_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Upper half of num is below den, so the remainder stays W bits wide
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[2*W-1:W];
            q_reg   <= num[W-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[W-1:0] : trial[W-1:0];
            q_reg   <= {q_reg[W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

/* design/window_slew_and_clamp_engine_top.sv */
// Top level of the window slew and clamp engine: window table, sequencer and ports.
//
// Keeps a table of WINDOWS overlay windows (current and goal centre/size) in one
// synchronous RAM row per window and handles one item at a time: set target, tick
// toward the target, or hide. Every item gives exactly one result item. Steps from
// one accepted item to the next: hide, the unused function code, an out-of-range
// window, a tick with nothing to do and an unbounded set target pass accept/read,
// finish and idle; a tick that moves adds the bounding steps S_BND1 to S_BND3; a
// bounded set target adds them too, then the aspect fix-up runs a multiply, a
// compare and, unless the requested height is zero, a one-bit-per-cycle divider of
// COORD_BITS steps. Each table row has a valid flop cleared by reset, so an
// unwritten window reads as all zero and no clearing pass is needed after reset. A
// finished result sits in the output register; the next item is taken while it
// waits, and the sequencer only stalls in its finish step if the previous result
// has still not been taken. Config writes are always accepted (cfg_ready is tied
// high) and must only be issued while the engine is idle.
module window_slew_and_clamp_engine_top #(
    parameter int WINDOWS    = wsce_pkg::WINDOWS_DEF,
    parameter int COORD_BITS = wsce_pkg::COORD_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // window[2:0], target_x[14:3], target_y[26:15], target_w[38:27],
    // target_h[50:39], bound_enable[51], zero fill [55:52]
    input  logic [wsce_pkg::S_TDATA_W-1:0]       s_tdata,
    // func[1:0]
    input  logic [wsce_pkg::FUNC_W-1:0]          s_tuser,
    // result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // window_out[2:0], cur_x[14:3], cur_y[26:15], cur_w[38:27], cur_h[50:39],
    // moved[51], degenerate[52], zero fill [55:53]
    output logic [wsce_pkg::M_TDATA_W-1:0]       m_tdata,
    // config writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wsce_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wsce_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW    = COORD_BITS;
    // signed working width: room for sums, differences and doubled sizes
    localparam int AW    = ((COORD_BITS > wsce_pkg::FIELD_W) ?
                            COORD_BITS : wsce_pkg::FIELD_W) + 3;
    localparam int IDX_W = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam logic signed [AW-1:0] COORD_MAX_A = AW'((1 << COORD_BITS) - 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_READ = 9'b000000010,
        S_BND1 = 9'b000000100,
        S_BND2 = 9'b000001000,
        S_BND3 = 9'b000010000,
        S_MUL  = 9'b000100000,
        S_CMP  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    typedef logic [wsce_pkg::ROW_FIELDS-1:0][CW-1:0] row_t;

    // Saturate a port-width value to the largest coordinate
    function automatic logic signed [AW-1:0] sat_c(input logic [wsce_pkg::FIELD_W-1:0] v);
        logic signed [AW-1:0] e;
        e = $signed(AW'(v));
        return (e > COORD_MAX_A) ? COORD_MAX_A : e;
    endfunction

    function automatic logic signed [AW-1:0] ext_c(input logic [CW-1:0] v);
        return $signed(AW'(v));
    endfunction

    // Move cur toward goal by at most st
    function automatic logic signed [AW-1:0] approach(input logic signed [AW-1:0] cur,
                                                     input logic signed [AW-1:0] goal,
                                                     input logic signed [AW-1:0] st);
        logic signed [AW-1:0] d;
        d = goal - cur;
        if (d > st) begin
            d = st;
        end else if (d < -st) begin
            d = -st;
        end
        return cur + d;
    endfunction

    // ---------------------------------------------------------------- config
    logic [wsce_pkg::CFG_DATA_W-1:0] fw_reg;
    logic [wsce_pkg::CFG_DATA_W-1:0] fh_reg;
    logic [wsce_pkg::CFG_DATA_W-1:0] step_reg;
    logic                            smooth_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg     <= wsce_pkg::FRAME_WIDTH_RST;
            fh_reg     <= wsce_pkg::FRAME_HEIGHT_RST;
            step_reg   <= wsce_pkg::MOVE_STEP_RST;
            smooth_reg <= wsce_pkg::SMOOTH_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                wsce_pkg::REG_FRAME_WIDTH:  fw_reg     <= cfg_data;
                wsce_pkg::REG_FRAME_HEIGHT: fh_reg     <= cfg_data;
                wsce_pkg::REG_MOVE_STEP:    step_reg   <= cfg_data;
                wsce_pkg::REG_SMOOTH:       smooth_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic signed [AW-1:0] fw_a;
    logic signed [AW-1:0] fh_a;
    logic signed [AW-1:0] st_a;

    assign fw_a = sat_c(fw_reg);
    assign fh_a = sat_c(fh_reg);
    assign st_a = $signed(AW'(step_reg));

    // ----------------------------------------------------------- window table
    row_t               mem [WINDOWS];
    row_t               rd_row_reg;
    logic [WINDOWS-1:0] valid_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    logic               mem_we;
    row_t               new_row;

    // ------------------------------------------------------------- sequencer
    state_t                     state_reg, state_next;
    logic [wsce_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [wsce_pkg::WIN_W-1:0] win_reg, win_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic                       in_range_reg, in_range_next;
    logic                       bound_en_reg, bound_en_next;
    logic                       bounded_reg, bounded_next;
    logic signed [AW-1:0]       x_reg, x_next;
    logic signed [AW-1:0]       y_reg, y_next;
    logic signed [AW-1:0]       w_reg, w_next;
    logic signed [AW-1:0]       h_reg, h_next;
    logic [CW-1:0]              rw_reg, rw_next;
    logic [CW-1:0]              rh_reg, rh_next;
    row_t                       old_row_reg, old_row_next;
    logic [2*CW-1:0]            p1_reg, p1_next;
    logic [2*CW-1:0]            p2_reg, p2_next;
    logic                       div_to_h_reg, div_to_h_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [wsce_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // divider hookup
    logic                  div_start;
    logic [2*CW-1:0]       div_num;
    logic [CW-1:0]         div_den;
    wsce_pkg::div_stat_t   div_stat;
    logic [CW-1:0]         div_quot;

    wsce_div #(
        .W (CW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign rd_en    = s_tvalid && s_tready;
    assign rd_idx   = IDX_W'(s_tdata[wsce_pkg::IN_WIN_LSB +: wsce_pkg::WIN_W]);

    // unwritten rows read as zero
    row_t row_in;
    assign row_in = valid_reg[idx_reg] ? rd_row_reg : '0;

    always_comb begin
        logic signed [AW-1:0] cx, cy, cw, ch, gx, gy, gw, gh;
        logic signed [AW-1:0] wt, ht;
        logic                 snap;
        logic                 adjust;
        logic                 fire;
        logic                 moved;
        logic                 degen;

        state_next    = state_reg;
        func_next     = func_reg;
        win_next      = win_reg;
        idx_next      = idx_reg;
        in_range_next = in_range_reg;
        bound_en_next = bound_en_reg;
        bounded_next  = bounded_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        rw_next       = rw_reg;
        rh_next       = rh_reg;
        old_row_next  = old_row_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        div_to_h_next = div_to_h_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        div_start     = 1'b0;
        div_num       = p1_reg;
        div_den       = rw_reg;
        mem_we        = 1'b0;
        new_row       = old_row_reg;

        cx = ext_c(row_in[wsce_pkg::F_NX]);
        cy = ext_c(row_in[wsce_pkg::F_NY]);
        cw = ext_c(row_in[wsce_pkg::F_NW]);
        ch = ext_c(row_in[wsce_pkg::F_NH]);
        gx = ext_c(row_in[wsce_pkg::F_GX]);
        gy = ext_c(row_in[wsce_pkg::F_GY]);
        gw = ext_c(row_in[wsce_pkg::F_GW]);
        gh = ext_c(row_in[wsce_pkg::F_GH]);
        snap   = (cw == '0) && (ch == '0);
        adjust = snap || (cx != gx) || (cy != gy) || (cw != gw) || (ch != gh);
        wt     = '0;
        ht     = '0;
        fire   = !m_tvalid_reg || m_tready;
        moved  = 1'b0;
        degen  = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (rd_en) begin
                    func_next     = s_tuser;
                    win_next      = s_tdata[wsce_pkg::IN_WIN_LSB +: wsce_pkg::WIN_W];
                    idx_next      = rd_idx;
                    in_range_next = (32'(s_tdata[wsce_pkg::IN_WIN_LSB +: wsce_pkg::WIN_W])
                                     < 32'(WINDOWS));
                    bound_en_next = s_tdata[wsce_pkg::IN_BOUND_BIT];
                    bounded_next  = 1'b0;
                    x_next  = sat_c(s_tdata[wsce_pkg::IN_X_LSB +: wsce_pkg::FIELD_W]);
                    y_next  = sat_c(s_tdata[wsce_pkg::IN_Y_LSB +: wsce_pkg::FIELD_W]);
                    w_next  = sat_c(s_tdata[wsce_pkg::IN_W_LSB +: wsce_pkg::FIELD_W]);
                    h_next  = sat_c(s_tdata[wsce_pkg::IN_H_LSB +: wsce_pkg::FIELD_W]);
                    rw_next = CW'(sat_c(s_tdata[wsce_pkg::IN_W_LSB +: wsce_pkg::FIELD_W]));
                    rh_next = CW'(sat_c(s_tdata[wsce_pkg::IN_H_LSB +: wsce_pkg::FIELD_W]));
                    state_next = S_READ;
                end
            end
            S_READ: begin
                old_row_next = row_in;
                state_next   = S_FIN;
                if (in_range_reg) begin
                    case (func_reg)
                        wsce_pkg::FUNC_SET: begin
                            // work regs already hold the saturated target
                            if (bound_en_reg) begin
                                bounded_next = 1'b1;
                                state_next   = S_BND1;
                            end
                        end
                        wsce_pkg::FUNC_TICK: begin
                            // a window with no size snaps to its goal size, centred
                            x_next = snap ? (gw >>> 1) : approach(cx, gx, st_a);
                            y_next = snap ? (gh >>> 1) : approach(cy, gy, st_a);
                            w_next = snap ? gw : approach(cw, gw, st_a);
                            h_next = snap ? gh : approach(ch, gh, st_a);
                            if (adjust) begin
                                bounded_next = 1'b1;
                                state_next   = S_BND1;
                            end
                        end
                        wsce_pkg::FUNC_HIDE: begin
                            x_next = cx;
                            y_next = cy;
                            w_next = '0;
                            h_next = '0;
                        end
                        default: begin
                            x_next = cx;
                            y_next = cy;
                            w_next = cw;
                            h_next = ch;
                        end
                    endcase
                end
            end
            S_BND1: begin
                // clamp size and centre to the frame
                w_next = (w_reg < 0) ? '0 : ((w_reg > fw_a) ? fw_a : w_reg);
                h_next = (h_reg < 0) ? '0 : ((h_reg > fh_a) ? fh_a : h_reg);
                x_next = (x_reg < 0) ? '0 : ((x_reg > fw_a) ? fw_a : x_reg);
                y_next = (y_reg < 0) ? '0 : ((y_reg > fh_a) ? fh_a : y_reg);
                state_next = S_BND2;
            end
            S_BND2: begin
                // left / top edge
                if (x_reg - (w_reg >>> 1) < 0) begin
                    w_next = x_reg <<< 1;
                end
                if (y_reg - (h_reg >>> 1) < 0) begin
                    h_next = y_reg <<< 1;
                end
                state_next = S_BND3;
            end
            S_BND3: begin
                // right / bottom edge, negative widths saturate to zero
                wt = (x_reg + (w_reg >>> 1) > fw_a) ? ((fw_a - x_reg - 1) <<< 1) : w_reg;
                ht = (y_reg + (h_reg >>> 1) > fh_a) ? ((fh_a - y_reg - 1) <<< 1) : h_reg;
                w_next = (wt < 0) ? '0 : wt;
                h_next = (ht < 0) ? '0 : ht;
                state_next = (func_reg == wsce_pkg::FUNC_SET) ? S_MUL : S_FIN;
            end
            S_MUL: begin
                p1_next = (2*CW)'(w_reg[CW-1:0]) * (2*CW)'(rh_reg);
                p2_next = (2*CW)'(rw_reg) * (2*CW)'(h_reg[CW-1:0]);
                state_next = S_CMP;
            end
            S_CMP: begin
                if (rh_reg == '0) begin
                    h_next     = '0;
                    state_next = S_FIN;
                end else begin
                    div_start = 1'b1;
                    if (p1_reg < p2_reg) begin
                        div_num       = p1_reg;
                        div_den       = rw_reg;
                        div_to_h_next = 1'b1;
                    end else begin
                        div_num       = p2_reg;
                        div_den       = rh_reg;
                        div_to_h_next = 1'b0;
                    end
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    if (div_to_h_reg) begin
                        h_next = ext_c(div_quot);
                    end else begin
                        w_next = ext_c(div_quot);
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                case (func_reg)
                    wsce_pkg::FUNC_SET: begin
                        new_row[wsce_pkg::F_GX] = x_reg[CW-1:0];
                        new_row[wsce_pkg::F_GY] = y_reg[CW-1:0];
                        new_row[wsce_pkg::F_GW] = w_reg[CW-1:0];
                        new_row[wsce_pkg::F_GH] = h_reg[CW-1:0];
                        if (!smooth_reg) begin
                            new_row[wsce_pkg::F_NX] = x_reg[CW-1:0];
                            new_row[wsce_pkg::F_NY] = y_reg[CW-1:0];
                            new_row[wsce_pkg::F_NW] = w_reg[CW-1:0];
                            new_row[wsce_pkg::F_NH] = h_reg[CW-1:0];
                        end
                    end
                    wsce_pkg::FUNC_TICK, wsce_pkg::FUNC_HIDE: begin
                        new_row[wsce_pkg::F_NX] = x_reg[CW-1:0];
                        new_row[wsce_pkg::F_NY] = y_reg[CW-1:0];
                        new_row[wsce_pkg::F_NW] = w_reg[CW-1:0];
                        new_row[wsce_pkg::F_NH] = h_reg[CW-1:0];
                    end
                    default: ;
                endcase
                moved = in_range_reg && (new_row[3:0] != old_row_reg[3:0]);
                degen = in_range_reg && bounded_reg && ((w_reg == '0) || (h_reg == '0));
                if (fire) begin
                    mem_we        = in_range_reg;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[wsce_pkg::OUT_WIN_LSB +: wsce_pkg::WIN_W] = win_reg;
                    if (in_range_reg) begin
                        m_tdata_next[wsce_pkg::OUT_X_LSB +: wsce_pkg::FIELD_W] =
                            wsce_pkg::FIELD_W'(new_row[wsce_pkg::F_NX]);
                        m_tdata_next[wsce_pkg::OUT_Y_LSB +: wsce_pkg::FIELD_W] =
                            wsce_pkg::FIELD_W'(new_row[wsce_pkg::F_NY]);
                        m_tdata_next[wsce_pkg::OUT_W_LSB +: wsce_pkg::FIELD_W] =
                            wsce_pkg::FIELD_W'(new_row[wsce_pkg::F_NW]);
                        m_tdata_next[wsce_pkg::OUT_H_LSB +: wsce_pkg::FIELD_W] =
                            wsce_pkg::FIELD_W'(new_row[wsce_pkg::F_NH]);
                    end
                    m_tdata_next[wsce_pkg::OUT_MOVED_BIT] = moved;
                    m_tdata_next[wsce_pkg::OUT_DEGEN_BIT] = degen;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            valid_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (mem_we) begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        win_reg      <= win_next;
        idx_reg      <= idx_next;
        in_range_reg <= in_range_next;
        bound_en_reg <= bound_en_next;
        bounded_reg  <= bounded_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        rw_reg       <= rw_next;
        rh_reg       <= rh_next;
        old_row_reg  <= old_row_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        div_to_h_reg <= div_to_h_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // window table RAM, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[idx_reg] <= new_row;
        end
        if (rd_en) begin
            rd_row_reg <= mem[rd_idx];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // -------------------------------------------------------------- checks
    // a row written back is marked valid on the next cycle
    a_row_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> valid_reg[$past(idx_reg)])
        else $error("written row not marked valid");

    // divider only runs while the sequencer waits on it
    a_div_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_stat.busy || div_stat.done) |-> (state_reg == S_DIV))
        else $error("divider active outside divide step");

    // a new result only comes out of the finish step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result raised outside finish step");

    // bounded size fits the frame before the aspect fix-up
    a_bound_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |-> ((w_reg >= 0) && (w_reg <= fw_a) &&
                                  (h_reg >= 0) && (h_reg <= fh_a)))
        else $error("bounded size outside frame");

endmodule

/* dv/testbench.sv */
// Self-checking bench for the window slew and clamp engine: random streams vs. a local predictor.
`timescale 1ns / 100ps

module testbench;
    import wsce_pkg::*;

    localparam int NUM_WIN     = WINDOWS_DEF;
    localparam int COORD_MAX   = (1 << COORD_BITS_DEF) - 1;
    localparam int IDLE_PCT    = 37;       // chance in 100 that a side idles in a cycle
    localparam int SETTLE      = 48;       // settling wait that covers the longest item
    localparam int HOLD_AT     = 700;      // items taken before the long output stall
    localparam int HOLD_LEN    = 300;
    localparam int CYCLE_LIMIT = 400000;

    // the function code the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [WIN_W-1:0]   win;
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] w;
        logic [FIELD_W-1:0] h;
        logic               bound;
    } window_req_t;

    typedef struct packed {
        logic [WIN_W-1:0]   win;
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] w;
        logic [FIELD_W-1:0] h;
        logic               moved;
        logic               degen;
    } window_rpt_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
    } reg_write_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [FUNC_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always #2 aclk = ~aclk;

    window_slew_and_clamp_engine_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    window_req_t pending_requests[$];   // items waiting for the driver
    window_rpt_t expected_reports[$];   // predicted results, oldest first
    reg_write_t  reg_writes[$];         // register writes waiting for the config driver
    window_req_t on_bus;                // item currently offered on s_tdata

    int  items_taken     = 0;
    int  results_checked = 0;
    int  mismatches      = 0;
    int  settings_run    = 1;           // reset values count as the first setting
    int  cycle_count     = 0;
    int  hold_left       = 0;
    bit  hold_done       = 1'b0;
    bit  steady_run      = 1'b0;        // both sides stop idling while set

    // predictor copy of the registers
    int  frame_w_cfg  = FRAME_WIDTH_RST;
    int  frame_h_cfg  = FRAME_HEIGHT_RST;
    int  step_cfg     = MOVE_STEP_RST;
    bit  smooth_cfg   = SMOOTH_RST;

    // predictor copy of the window table; zero after reset
    int  now_x [NUM_WIN];
    int  now_y [NUM_WIN];
    int  now_w [NUM_WIN];
    int  now_h [NUM_WIN];
    int  goal_x [NUM_WIN];
    int  goal_y [NUM_WIN];
    int  goal_w [NUM_WIN];
    int  goal_h [NUM_WIN];

    // ------------------------------------------------------------------
    // Window predictor
    // ------------------------------------------------------------------
    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    function automatic int step_toward(int cur, int goal, int st);
        return cur + clamp_int(goal - cur, -st, st);
    endfunction

    // Clamp box to the frame; an edge overrun shrinks the size, negative sizes become 0.
    function automatic void fit_to_frame(inout int x, inout int y, inout int w, inout int h);
        w = clamp_int(w, 0, frame_w_cfg);
        h = clamp_int(h, 0, frame_h_cfg);
        x = clamp_int(x, 0, frame_w_cfg);
        y = clamp_int(y, 0, frame_h_cfg);
        if (x - w / 2 < 0) w = x * 2;
        if (y - h / 2 < 0) h = y * 2;
        if (x + w / 2 > frame_w_cfg) w = (frame_w_cfg - x - 1) * 2;
        if (y + h / 2 > frame_h_cfg) h = (frame_h_cfg - y - 1) * 2;
        if (w < 0) w = 0;
        if (h < 0) h = 0;
    endfunction

    // Applies one item to the table copy and returns the result it should produce.
    function automatic window_rpt_t advance_window(window_req_t req);
        window_rpt_t r;
        int          n, x0, y0, w0, h0, x, y, w, h;
        longint      rw, rh;
        bit          degen, adjust;
        r      = '0;
        r.win  = req.win;
        n      = req.win;
        x0     = now_x[n];
        y0     = now_y[n];
        w0     = now_w[n];
        h0     = now_h[n];
        degen  = 1'b0;
        adjust = 1'b0;
        case (req.func)
            FUNC_SET: begin
                x = req.x;
                y = req.y;
                w = req.w;
                h = req.h;
                if (req.bound) begin
                    rw = w;
                    rh = h;
                    fit_to_frame(x, y, w, h);
                    // aspect fix-up by cross multiplication
                    if (rh == 0)
                        h = 0;
                    else if (longint'(w) * rh < rw * longint'(h))
                        h = int'((longint'(w) * rh) / rw);
                    else
                        w = int'((longint'(h) * rw) / rh);
                    degen = (w == 0 || h == 0);
                end
                goal_x[n] = x;
                goal_y[n] = y;
                goal_w[n] = w;
                goal_h[n] = h;
                if (!smooth_cfg) begin
                    now_x[n] = x;
                    now_y[n] = y;
                    now_w[n] = w;
                    now_h[n] = h;
                end
            end
            FUNC_TICK: begin
                x = x0;
                y = y0;
                w = w0;
                h = h0;
                if (x != goal_x[n]) begin
                    x = step_toward(x, goal_x[n], step_cfg);
                    adjust = 1'b1;
                end
                if (y != goal_y[n]) begin
                    y = step_toward(y, goal_y[n], step_cfg);
                    adjust = 1'b1;
                end
                // a hidden or fresh window snaps to its goal size, centre at half size
                if (w == 0 && h == 0) begin
                    w = goal_w[n];
                    h = goal_h[n];
                    x = w / 2;
                    y = h / 2;
                    adjust = 1'b1;
                end
                if (w != goal_w[n]) begin
                    w = step_toward(w, goal_w[n], step_cfg);
                    adjust = 1'b1;
                end
                if (h != goal_h[n]) begin
                    h = step_toward(h, goal_h[n], step_cfg);
                    adjust = 1'b1;
                end
                if (adjust) begin
                    fit_to_frame(x, y, w, h);
                    degen = (w == 0 || h == 0);
                end
                now_x[n] = x;
                now_y[n] = y;
                now_w[n] = w;
                now_h[n] = h;
            end
            FUNC_HIDE: begin
                now_w[n] = 0;
                now_h[n] = 0;
            end
            default: ;  // unused code only reports
        endcase
        r.x     = now_x[n][FIELD_W-1:0];
        r.y     = now_y[n][FIELD_W-1:0];
        r.w     = now_w[n][FIELD_W-1:0];
        r.h     = now_h[n][FIELD_W-1:0];
        r.moved = (now_x[n] != x0 || now_y[n] != y0 || now_w[n] != w0 || now_h[n] != h0);
        r.degen = degen;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers queued items, idles at random, holds an item
    // stable until it is taken, predicts each accepted item
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_reports.push_back(advance_window(on_bus));
                items_taken <= items_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 &&
                    (steady_run || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    on_bus   = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, on_bus.bound, on_bus.h, on_bus.w, on_bus.y,
                                 on_bus.x, on_bus.win};
                    s_tuser  <= on_bus.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Config driver: register writes only issued by the sequence while idle
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        reg_write_t wr;
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_w_cfg = cfg_data;
                    REG_FRAME_HEIGHT: frame_h_cfg = cfg_data;
                    REG_MOVE_STEP:    step_cfg    = cfg_data;
                    REG_SMOOTH:       smooth_cfg  = cfg_data[0];
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_writes.size() != 0) begin
                    wr        = reg_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= wr.idx;
                    cfg_data  <= wr.val;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output ready: random back-pressure plus one long stall, counted here,
    // so the engine backs up and stops taking items
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && items_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= steady_run || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at result %0d: %s got %0d, expected %0d",
                     results_checked, what, got, want);
    endtask

    always @(posedge aclk) begin
        window_rpt_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected result, window", m_tdata[OUT_WIN_LSB +: WIN_W], -1);
            end else begin
                want = expected_reports.pop_front();
                if (m_tdata[OUT_WIN_LSB +: WIN_W] != want.win)
                    report_mismatch("window_out", m_tdata[OUT_WIN_LSB +: WIN_W], want.win);
                if (m_tdata[OUT_X_LSB +: FIELD_W] != want.x)
                    report_mismatch("cur_x", m_tdata[OUT_X_LSB +: FIELD_W], want.x);
                if (m_tdata[OUT_Y_LSB +: FIELD_W] != want.y)
                    report_mismatch("cur_y", m_tdata[OUT_Y_LSB +: FIELD_W], want.y);
                if (m_tdata[OUT_W_LSB +: FIELD_W] != want.w)
                    report_mismatch("cur_w", m_tdata[OUT_W_LSB +: FIELD_W], want.w);
                if (m_tdata[OUT_H_LSB +: FIELD_W] != want.h)
                    report_mismatch("cur_h", m_tdata[OUT_H_LSB +: FIELD_W], want.h);
                if (m_tdata[OUT_MOVED_BIT] != want.moved)
                    report_mismatch("moved", m_tdata[OUT_MOVED_BIT], want.moved);
                if (m_tdata[OUT_DEGEN_BIT] != want.degen)
                    report_mismatch("degenerate", m_tdata[OUT_DEGEN_BIT], want.degen);
            end
            results_checked++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_reports.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence; runs on the falling edge so queue updates never
    // share a time step with the clocked processes above
    // ------------------------------------------------------------------
    task automatic queue_request(logic [FUNC_W-1:0] f, int win, int x, int y, int w, int h,
                                 bit bound);
        window_req_t r;
        r.func  = f;
        r.win   = win[WIN_W-1:0];
        r.x     = x[FIELD_W-1:0];
        r.y     = y[FIELD_W-1:0];
        r.w     = w[FIELD_W-1:0];
        r.h     = h[FIELD_W-1:0];
        r.bound = bound;
        pending_requests.push_back(r);
    endtask

    // Coordinates mostly inside the frame, with the field extremes and frame edges mixed in.
    function automatic int pick_coord(int limit);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return COORD_MAX;
            2, 3:    return $urandom_range(0, limit);
            4:       return $urandom_range(0, COORD_MAX);
            default: return $urandom_range(limit > 8 ? limit - 8 : 0,
                                           limit + 8 > COORD_MAX ? COORD_MAX : limit + 8);
        endcase
    endfunction

    task automatic wait_for_results();
        while (pending_requests.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(negedge aclk);
    endtask

    task automatic program_engine(int fw, int fh, int st, bit smooth);
        wait_for_results();
        repeat (SETTLE) @(negedge aclk);
        reg_writes.push_back('{REG_FRAME_WIDTH,  fw[CFG_DATA_W-1:0]});
        reg_writes.push_back('{REG_FRAME_HEIGHT, fh[CFG_DATA_W-1:0]});
        reg_writes.push_back('{REG_MOVE_STEP,    st[CFG_DATA_W-1:0]});
        reg_writes.push_back('{REG_SMOOTH,       CFG_DATA_W'(smooth)});
        while (reg_writes.size() != 0 || cfg_valid) @(negedge aclk);
        settings_run++;
    endtask

    // Mostly a set target followed by a run of ticks on the same window;
    // some bursts hide first, some are plain noise over every field.
    task automatic queue_window_burst(output int count);
        int win, ticks, other;
        win   = $urandom_range(0, NUM_WIN - 1);
        ticks = $urandom_range(1, 14);
        count = 0;
        case ($urandom_range(0, 9))
            0: begin
                repeat (4) begin
                    queue_request($urandom_range(0, 3), $urandom_range(0, NUM_WIN - 1),
                                  $urandom, $urandom, $urandom, $urandom,
                                  $urandom_range(0, 1));
                    count++;
                end
            end
            1: begin
                queue_request(FUNC_HIDE, win, $urandom, $urandom, $urandom, $urandom,
                              $urandom_range(0, 1));
                count++;
            end
            default: begin
                queue_request(FUNC_SET, win, pick_coord(frame_w_cfg), pick_coord(frame_h_cfg),
                              pick_coord(frame_w_cfg), pick_coord(frame_h_cfg),
                              $urandom_range(0, 3) != 0);
                count++;
            end
        endcase
        repeat (ticks) begin
            other = $urandom_range(0, NUM_WIN - 1);
            case ($urandom_range(0, 19))
                0:       queue_request(FUNC_UNUSED, win, $urandom, $urandom, $urandom,
                                       $urandom, $urandom_range(0, 1));
                1:       queue_request(FUNC_TICK, other, $urandom, $urandom, $urandom,
                                       $urandom, $urandom_range(0, 1));
                default: queue_request(FUNC_TICK, win, $urandom, $urandom, $urandom,
                                       $urandom, $urandom_range(0, 1));
            endcase
            count++;
        end
    endtask

    task automatic queue_random_items(int total);
        int done, n;
        done = 0;
        while (done < total) begin
            // keep the driver fed, but now and then let everything drain first
            while (pending_requests.size() > 16) @(negedge aclk);
            if ($urandom_range(0, 11) == 0) wait_for_results();
            queue_window_burst(n);
            done += n;
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at reset values: 640 x 480, step 20, smoothing on
        queue_request(FUNC_SET,  0, 320, 240, 200, 100, 1);
        queue_request(FUNC_TICK, 0, 0, 0, 0, 0, 0);              // zero-size snap
        queue_request(FUNC_TICK, 0, 0, 0, 0, 0, 0);
        queue_request(FUNC_HIDE, 0, 0, 0, 0, 0, 0);
        queue_request(FUNC_TICK, 0, 0, 0, 0, 0, 0);              // snap after hide
        queue_request(FUNC_UNUSED, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
        queue_request(FUNC_SET,  1, 0, 0, 0, 0, 1);              // zero height goal
        queue_request(FUNC_TICK, 1, 0, 0, 0, 0, 0);
        queue_request(FUNC_SET,  2, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
        queue_request(FUNC_TICK, 2, 0, 0, 0, 0, 0);
        queue_request(FUNC_SET,  3, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
        queue_request(FUNC_TICK, 3, 0, 0, 0, 0, 0);
        queue_request(FUNC_SET,  4, 0, 240, 400, 300, 1);        // left edge overrun
        queue_request(FUNC_SET,  5, 640, 480, 100, 100, 1);      // right edge goes negative
        queue_request(FUNC_SET,  6, 600, 20, 300, 100, 1);       // right edge shrink
        queue_request(FUNC_TICK, 6, 0, 0, 0, 0, 0);
        queue_request(FUNC_TICK, 6, 0, 0, 0, 0, 0);
        queue_request(FUNC_SET,  7, 100, 100, 0, 50, 1);         // zero requested width
        queue_request(FUNC_TICK, 7, 0, 0, 0, 0, 0);
        queue_request(FUNC_HIDE, 7, 0, 0, 0, 0, 0);
        queue_request(FUNC_TICK, 5, 0, 0, 0, 0, 0);
        queue_random_items(200);

        // Settings sweep, extremes first
        program_engine(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);   // jumps, so ticks often idle
        queue_random_items(200);
        program_engine(1, 1, 0, 1'b1);                           // tiny frame, zero step
        queue_random_items(200);
        program_engine($urandom_range(16, COORD_MAX), $urandom_range(16, COORD_MAX),
                       $urandom_range(1, 64), 1'b1);
        queue_random_items(200);
        program_engine(COORD_MAX, 1, 1, 1'b1);
        queue_random_items(200);
        program_engine(1, COORD_MAX, COORD_MAX, 1'b0);
        queue_random_items(200);
        program_engine($urandom_range(1, COORD_MAX), $urandom_range(1, COORD_MAX), 0, 1'b1);
        queue_random_items(200);

        // Back-to-back stretch with no idling on either side
        program_engine(800, 600, 7, 1'b1);
        steady_run = 1'b1;
        queue_random_items(200);

        wait_for_results();
        repeat (SETTLE) @(negedge aclk);
        steady_run = 1'b0;

        if (expected_reports.size() != 0)
            report_mismatch("results never delivered", 0, expected_reports.size());
        $display("run covered %0d items and %0d results over %0d register settings",
                 items_taken, results_checked, settings_run);
        $display("including one %0d-cycle output stall and %0d mismatches",
                 HOLD_LEN, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
